[design/lpr_pkg.sv]
// Package for the line pixel rasterizer: coordinate widths, line kinds,
// minor step codes, word and state types, and the coordinate step helper.
// No dependencies.
package lpr_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic [2:0] {
    KIND_HORIZ   = 3'd0,
    KIND_VERT    = 3'd1,
    KIND_DIAG    = 3'd2,
    KIND_SHALLOW = 3'd3,
    KIND_STEEP   = 3'd4
  } kind_e;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic   operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_word_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_word_t;

  typedef struct packed {
    logic       active;
    kind_e      kind;
    coord_t     cur_x;
    coord_t     cur_y;
    coord_t     major_end;
    coord_t     delta_major;
    coord_t     delta_minor;
    err_t       error_term;
    logic [1:0] minor_dir;
  } line_state_t;

  function automatic coord_t step_coord(input coord_t v, input logic [1:0] dir);
    coord_t r;
    r = v;
    if (dir == DIR_POS) begin
      r = v + coord_t'(1);
    end else if (dir == DIR_NEG) begin
      r = v - coord_t'(1);
    end
    return r;
  endfunction

  // 2*a - b at error term width
  function automatic err_t twice_minus(input coord_t a, input coord_t b);
    return $signed({2'b00, a, 1'b0}) - $signed({3'b000, b});
  endfunction

endpackage

[design/lpr_setup.sv]
// Load decode: sorts a new line into its kind and builds its first pixel
// and walking state. Depends on lpr_pkg.
module lpr_setup (
  input  lpr_pkg::in_word_t    word_i,
  output lpr_pkg::line_state_t state_o,
  output logic                 last_o
);

  lpr_pkg::coord_t x1, y1, x2, y2, adx, ady;
  logic            x_gt, y_gt, x_lt, y_lt;
  logic [1:0]      same_dir;

  always_comb begin
    x1   = word_i.x_start;
    y1   = word_i.y_start;
    x2   = word_i.x_end;
    y2   = word_i.y_end;
    x_gt = x2 > x1;
    y_gt = y2 > y1;
    x_lt = x1 < x2;
    y_lt = y1 < y2;
    adx  = x_gt ? x2 - x1 : x1 - x2;
    ady  = y_gt ? y2 - y1 : y1 - y2;
    same_dir = (x_gt == y_gt) ? lpr_pkg::DIR_POS : lpr_pkg::DIR_NEG;

    state_o = '0;
    priority if (y1 == y2) begin
      state_o.kind        = lpr_pkg::KIND_HORIZ;
      state_o.cur_x       = x_lt ? x1 : x2;
      state_o.cur_y       = y1;
      state_o.major_end   = x_lt ? x2 : x1;
      state_o.delta_major = adx;
      state_o.delta_minor = '0;
      state_o.minor_dir   = lpr_pkg::DIR_NONE;
    end else if (x1 == x2) begin
      state_o.kind        = lpr_pkg::KIND_VERT;
      state_o.cur_x       = x1;
      state_o.cur_y       = y_lt ? y1 : y2;
      state_o.major_end   = y_lt ? y2 : y1;
      state_o.delta_major = ady;
      state_o.delta_minor = '0;
      state_o.minor_dir   = lpr_pkg::DIR_NONE;
    end else if (adx == ady) begin
      state_o.kind        = lpr_pkg::KIND_DIAG;
      state_o.cur_x       = x1;
      state_o.cur_y       = y1;
      state_o.major_end   = x2;
      state_o.delta_major = adx;
      state_o.delta_minor = ady;
      state_o.minor_dir   = y_gt ? lpr_pkg::DIR_POS : lpr_pkg::DIR_NEG;
    end else if (ady < adx) begin
      state_o.kind        = lpr_pkg::KIND_SHALLOW;
      state_o.cur_x       = x_lt ? x1 : x2;
      state_o.cur_y       = x_lt ? y1 : y2;
      state_o.major_end   = x_lt ? x2 : x1;
      state_o.delta_major = adx;
      state_o.delta_minor = ady;
      state_o.minor_dir   = same_dir;
    end else begin
      state_o.kind        = lpr_pkg::KIND_STEEP;
      state_o.cur_x       = y_lt ? x1 : x2;
      state_o.cur_y       = y_lt ? y1 : y2;
      state_o.major_end   = y_lt ? y2 : y1;
      state_o.delta_major = ady;
      state_o.delta_minor = adx;
      state_o.minor_dir   = same_dir;
    end
    state_o.error_term = lpr_pkg::twice_minus(state_o.delta_minor, state_o.delta_major);
    last_o             = (state_o.delta_major == '0);
    state_o.active     = !last_o;
  end

endmodule

[design/lpr_walk.sv]
// Step logic: advances the active line by one pixel, using the Bresenham
// error term for shallow and steep lines. Depends on lpr_pkg.
module lpr_walk (
  input  lpr_pkg::line_state_t state_i,
  output lpr_pkg::line_state_t state_o,
  output logic                 emit_o,
  output logic                 last_o
);

  lpr_pkg::err_t inc_keep, inc_step;
  logic          err_le0;
  logic [1:0]    diag_xdir;

  always_comb begin
    inc_keep  = $signed({2'b00, state_i.delta_minor, 1'b0});
    inc_step  = $signed({2'b00, state_i.delta_minor, 1'b0})
              - $signed({2'b00, state_i.delta_major, 1'b0});
    err_le0   = state_i.error_term[lpr_pkg::ERR_BITS-1] || (state_i.error_term == '0);
    diag_xdir = (state_i.cur_x < state_i.major_end) ? lpr_pkg::DIR_POS : lpr_pkg::DIR_NEG;

    state_o = state_i;
    last_o  = 1'b0;
    emit_o  = state_i.active;
    if (state_i.active) begin
      unique case (state_i.kind)
        lpr_pkg::KIND_HORIZ: begin
          state_o.cur_x = state_i.cur_x + lpr_pkg::coord_t'(1);
          last_o        = (state_o.cur_x == state_i.major_end);
        end
        lpr_pkg::KIND_VERT: begin
          state_o.cur_y = state_i.cur_y + lpr_pkg::coord_t'(1);
          last_o        = (state_o.cur_y == state_i.major_end);
        end
        lpr_pkg::KIND_DIAG: begin
          state_o.cur_x = lpr_pkg::step_coord(state_i.cur_x, diag_xdir);
          state_o.cur_y = lpr_pkg::step_coord(state_i.cur_y, state_i.minor_dir);
          last_o        = (state_o.cur_x == state_i.major_end);
        end
        lpr_pkg::KIND_SHALLOW: begin
          if (err_le0) begin
            state_o.error_term = state_i.error_term + inc_keep;
          end else begin
            state_o.error_term = state_i.error_term + inc_step;
            state_o.cur_y      = lpr_pkg::step_coord(state_i.cur_y, state_i.minor_dir);
          end
          state_o.cur_x = state_i.cur_x + lpr_pkg::coord_t'(1);
          last_o        = (state_o.cur_x == state_i.major_end);
        end
        default: begin
          if (err_le0) begin
            state_o.error_term = state_i.error_term + inc_keep;
          end else begin
            state_o.error_term = state_i.error_term + inc_step;
            state_o.cur_x      = lpr_pkg::step_coord(state_i.cur_x, state_i.minor_dir);
          end
          state_o.cur_y = state_i.cur_y + lpr_pkg::coord_t'(1);
          last_o        = (state_o.cur_y == state_i.major_end);
        end
      endcase
      if (last_o) begin
        state_o.active = 1'b0;
      end
    end
  end

endmodule

[design/line_pixel_rasterizer_top.sv]
// Top level of the line pixel rasterizer: input register, line state,
// result register. Depends on lpr_pkg, lpr_setup and lpr_walk.
//
// Usage: the input channel (in_valid_i / in_stall_o / in_data_i) takes one
// word per cycle while in_stall_o is low. A load word (operation 0) starts
// a new line from its two endpoints and yields the first pixel; a step word
// (operation 1) yields the next pixel, with last_pixel set on the final one.
// A step word with no line in progress yields nothing. A load drops any line
// in progress. The output channel (out_valid_o / out_stall_i / out_data_o)
// carries one pixel word per result.
// An accepted word is held in the input register, and its pixel goes to the
// result register that drives out_data_o. Throughput: one word per cycle when
// not stalled, set by the single register-to-register pass through the setup
// and step logic. When the receiver stalls, the result register holds its
// word, the input register holds one more word, and then in_stall_o rises.
// Reset clears both valid flags and leaves no line in progress.
module line_pixel_rasterizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpr_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpr_pkg::out_word_t  out_data_o
);

  logic                 in_valid_q, in_valid_d;
  lpr_pkg::in_word_t    in_data_q;
  logic                 out_valid_q, out_valid_d;
  lpr_pkg::out_word_t   out_data_q, out_data_d;
  lpr_pkg::line_state_t state_q, state_d;

  lpr_pkg::line_state_t load_state, walk_state;
  logic                 load_last, walk_last, walk_emit;
  logic                 out_blocked, advance, in_accept, emit;

  lpr_setup u_setup (
    .word_i  (in_data_q),
    .state_o (load_state),
    .last_o  (load_last)
  );

  lpr_walk u_walk (
    .state_i (state_q),
    .state_o (walk_state),
    .emit_o  (walk_emit),
    .last_o  (walk_last)
  );

  assign out_blocked = out_valid_q && out_stall_i;
  assign advance     = in_valid_q && !out_blocked;
  assign in_stall_o  = in_valid_q && out_blocked;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    state_d    = state_q;
    out_data_d = out_data_q;
    emit       = 1'b0;
    if (advance) begin
      if (in_data_q.operation == lpr_pkg::OP_LOAD) begin
        state_d    = load_state;
        emit       = 1'b1;
        out_data_d = '{pixel_x: load_state.cur_x, pixel_y: load_state.cur_y,
                       last_pixel: load_last};
      end else begin
        state_d    = walk_state;
        emit       = walk_emit;
        out_data_d = '{pixel_x: walk_state.cur_x, pixel_y: walk_state.cur_y,
                       last_pixel: walk_last};
      end
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
